@@ design/wmm_pkg.sv @@
// ----------------------------------------------------------------------------
// wmm_pkg : shared types and constants of the window median/min/max filter
// Request payloads of both channels and the control word of the cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wmm_pkg;

    // sample width, fixed by the request payload
    localparam int SAMPLE_BITS = 16;
    // default window length
    localparam int WINDOW_DEF  = 3;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // input request
    typedef struct packed {
        sample_t sample;
        logic    frame_end;
    } in_req_t;

    // result request
    typedef struct packed {
        sample_t median_value;
        sample_t min_value;
        sample_t max_value;
        logic    last_of_frame;
    } out_req_t;

    // control word broadcast to every cell
    typedef struct packed {
        logic shift;  // drop the oldest sample, insert the new one
        logic clear;  // reload the window with zeros
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ design/window_median_min_max_filter.sv @@
// Latency: the result for a window is shown in the cycle after the sample that
//   completes it is accepted; outputs lag the input stream by WINDOW/2 samples.
// Throughput: one sample per cycle while no result is stalled and no flush runs;
//   a frame-end sample starts a flush of the window in which no sample is taken.
// Reset: synchronous, active low; window cleared to zeros, no result pending.
// ----------------------------------------------------------------------------
// window_median_min_max_filter : sliding window median / min / max
// Keeps the window sorted in a row of cells and registers one result request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module window_median_min_max_filter #(
    parameter int WINDOW = wmm_pkg::WINDOW_DEF
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  wmm_pkg::in_req_t   s_data,
    output logic               m_valid,
    input  wire                m_ready,
    output wmm_pkg::out_req_t  m_data
);
    import wmm_pkg::*;

    localparam int RIGHT = WINDOW / 2;
    localparam int FW    = $clog2(RIGHT + 2);
    localparam int KW    = $clog2(RIGHT + 1);
    localparam int SW    = $clog2(2 * RIGHT + 2);

    logic [FW-1:0] fill_reg, fill_next, fill_inc;
    logic [KW-1:0] step_reg, step_next;
    logic          flush_reg, flush_next;
    logic          m_valid_reg, m_valid_next;
    out_req_t      out_reg;

    logic       slot_free, take_in, flush_step, last_step, emit;
    cell_ctrl_t ctrl;
    sample_t    x, min_n, med_n, max_n;

    // handshake and step control
    always_comb begin
        slot_free  = !m_valid_reg || m_ready;
        s_ready    = !flush_reg && slot_free;
        take_in    = s_valid && s_ready;
        flush_step = flush_reg && slot_free;
        last_step  = flush_step && (step_reg == KW'(RIGHT));
        fill_inc   = (fill_reg == FW'(RIGHT + 1)) ? fill_reg : fill_reg + FW'(1);
        x          = take_in ? s_data.sample : '0;
        ctrl.shift = take_in || flush_step;
        ctrl.clear = last_step;
        if (take_in) begin
            emit = fill_inc > FW'(RIGHT);
        end else begin
            emit = flush_step && ((SW'(fill_reg) + SW'(step_reg)) >= SW'(RIGHT + 1));
        end
    end

    // frame fill and flush sequencing
    always_comb begin
        fill_next  = fill_reg;
        step_next  = step_reg;
        flush_next = flush_reg;
        if (take_in) begin
            fill_next = fill_inc;
            if (s_data.frame_end) begin
                flush_next = 1'b1;
                step_next  = KW'(1);
            end
        end else if (flush_step) begin
            step_next = step_reg + KW'(1);
            if (last_step) begin
                flush_next = 1'b0;
                fill_next  = '0;
            end
        end
    end

    always_comb begin
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            step_reg    <= '0;
            flush_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            step_reg    <= step_next;
            flush_reg   <= flush_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg.median_value  <= med_n;
            out_reg.min_value     <= min_n;
            out_reg.max_value     <= max_n;
            out_reg.last_of_frame <= last_step;
        end
    end

    wmm_chain #(
        .WINDOW (WINDOW)
    ) u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .x        (x),
        .min_next (min_n),
        .med_next (med_n),
        .max_next (max_n)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

@@ design/wmm_cell.sv @@
// ----------------------------------------------------------------------------
// wmm_cell : one slot of the sorted window
// Holds a value and its age; on a shift it takes its own value, a neighbour's
// value or the new sample so that the row stays sorted ascending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wmm_cell #(
    parameter int WINDOW = wmm_pkg::WINDOW_DEF,
    parameter int INDEX  = 0,
    parameter int AW     = $clog2(WINDOW)
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wmm_pkg::cell_ctrl_t  ctrl,
    input  wmm_pkg::sample_t     x,
    // left neighbour (lower values)
    input  wmm_pkg::sample_t     left_val,
    input  wire [AW-1:0]         left_age,
    input  wire                  left_h,
    input  wire                  left_d,
    // right neighbour (higher values)
    input  wmm_pkg::sample_t     right_val,
    input  wire [AW-1:0]         right_age,
    input  wire                  right_g,
    // own state and chain signals
    output wmm_pkg::sample_t     val,
    output logic [AW-1:0]        age,
    output logic                 h,
    output logic                 d,
    output logic                 g,
    output wmm_pkg::sample_t     nval
);
    import wmm_pkg::*;

    sample_t       val_reg, val_next;
    logic [AW-1:0] age_reg, age_next;
    sample_t       rem_val, prev_val;
    logic [AW-1:0] rem_age, prev_age;

    // removal point and insertion point
    always_comb begin
        d = left_d | (age_reg == AW'(WINDOW - 1));
        g = val_reg > x;
        if (INDEX == WINDOW - 1) begin
            h = 1'b1;
        end else begin
            h = d ? right_g : g;
        end
    end

    // neighbour values once the oldest entry is taken out
    always_comb begin
        rem_val  = d ? right_val : val_reg;
        rem_age  = d ? right_age : age_reg;
        prev_val = left_d ? val_reg : left_val;
        prev_age = left_d ? age_reg : left_age;
    end

    // new slot contents
    always_comb begin
        if (left_h) begin
            val_next = prev_val;
            age_next = prev_age + AW'(1);
        end else if (h) begin
            val_next = x;
            age_next = '0;
        end else begin
            val_next = rem_val;
            age_next = rem_age + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            val_reg <= '0;
            age_reg <= AW'(INDEX);
        end else if (ctrl.shift) begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

    assign val  = val_reg;
    assign age  = age_reg;
    assign nval = val_next;

endmodule

`default_nettype wire

@@ design/wmm_chain.sv @@
// ----------------------------------------------------------------------------
// wmm_chain : row of sorted window cells
// Links WINDOW cells and taps the post-shift minimum, median and maximum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wmm_chain #(
    parameter int WINDOW = wmm_pkg::WINDOW_DEF
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wmm_pkg::cell_ctrl_t  ctrl,
    input  wmm_pkg::sample_t     x,
    output wmm_pkg::sample_t     min_next,
    output wmm_pkg::sample_t     med_next,
    output wmm_pkg::sample_t     max_next
);
    import wmm_pkg::*;

    localparam int AW = $clog2(WINDOW);

    sample_t       val  [WINDOW];
    sample_t       nval [WINDOW];
    logic [AW-1:0] age  [WINDOW];
    logic          h    [WINDOW];
    logic          d    [WINDOW];
    logic          g    [WINDOW];

    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
        sample_t       lv, rv;
        logic [AW-1:0] la, ra;
        logic          lh, ld, rg;

        // neighbour links, tied off at both ends of the row
        if (i == 0) begin : g_first
            assign lv = '0;
            assign la = '0;
            assign lh = 1'b0;
            assign ld = 1'b0;
        end else begin : g_left
            assign lv = val[i-1];
            assign la = age[i-1];
            assign lh = h[i-1];
            assign ld = d[i-1];
        end
        if (i == WINDOW - 1) begin : g_last
            assign rv = '0;
            assign ra = '0;
            assign rg = 1'b0;
        end else begin : g_right
            assign rv = val[i+1];
            assign ra = age[i+1];
            assign rg = g[i+1];
        end

        wmm_cell #(
            .WINDOW (WINDOW),
            .INDEX  (i),
            .AW     (AW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .x         (x),
            .left_val  (lv),
            .left_age  (la),
            .left_h    (lh),
            .left_d    (ld),
            .right_val (rv),
            .right_age (ra),
            .right_g   (rg),
            .val       (val[i]),
            .age       (age[i]),
            .h         (h[i]),
            .d         (d[i]),
            .g         (g[i]),
            .nval      (nval[i])
        );
    end

    assign min_next = nval[0];
    assign med_next = nval[WINDOW/2];
    assign max_next = nval[WINDOW-1];

endmodule

`default_nettype wire

@@ design/wmm_checker.sv @@
// ----------------------------------------------------------------------------
// wmm_checker : port-level checks of the window filter
// Watches both request channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wmm_checker (
    input wire                aclk,
    input wire                aresetn,
    input wire                s_valid,
    input wire                s_ready,
    input wmm_pkg::in_req_t   s_data,
    input wire                m_valid,
    input wire                m_ready,
    input wmm_pkg::out_req_t  m_data
);
    import wmm_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // nothing pending after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // ordering of the three statistics
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.min_value <= m_data.median_value) &&
                    (m_data.median_value <= m_data.max_value))
        else $error("min / median / max out of order");

    // a stalled result blocks the input
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result stalled");

    // frame end starts the flush
    a_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.frame_end |=> !s_ready)
        else $error("input taken during frame flush");

endmodule

bind window_median_min_max_filter wmm_checker u_wmm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
